>>> src/drs_pkg.sv
// shared types and constants for the disk request scheduler
`default_nettype none
package drs_pkg;
  localparam int QueueDepth = 32;
  localparam int TrackBits = 16;
  localparam int TagBits = 16;
  localparam int IdxBits = $clog2(QueueDepth);
  localparam int CntBits = $clog2(QueueDepth + 1);

  typedef logic [TrackBits-1:0] track_t;
  typedef logic [TagBits-1:0] tag_t;
  typedef logic [CntBits-1:0] cnt_t;
  typedef logic [IdxBits-1:0] idx_t;

  typedef enum logic [1:0] {
    OP_ENQ = 2'd0,
    OP_ISSUE = 2'd1,
    OP_DONE = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_ENQ = 3'd0,
    ST_DROP = 3'd1,
    ST_ISSUED = 3'd2,
    ST_NONE = 3'd3,
    ST_DONE = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    MODE_FIFO = 3'd0,
    MODE_SSTF = 3'd1,
    MODE_LOOK = 3'd2,
    MODE_CLOOK = 3'd3,
    MODE_FLOOK = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_OUT
  } fsm_t;

  // one table entry
  typedef struct packed {
    track_t trk;
    tag_t tg;
  } entry_t;

  // control from the sequencer to the table cells
  typedef struct packed {
    logic push;
    logic shift;
    logic load;
    idx_t remove_idx;
    entry_t push_data;
  } cell_ctl_t;
endpackage
`default_nettype wire

>>> src/drs_if.sv
// valid/ready channel interfaces for requests and results
`default_nettype none
interface drs_req_if (input wire logic clk);
  logic valid;
  logic ready;
  logic [1:0] opcode;
  drs_pkg::track_t request_track;
  drs_pkg::tag_t request_tag;
  modport source (output valid, output opcode, output request_track, output request_tag,
    input ready);
  modport sink (input valid, input opcode, input request_track, input request_tag,
    output ready);
endinterface

interface drs_rsp_if (input wire logic clk);
  logic valid;
  logic ready;
  logic [2:0] status;
  drs_pkg::track_t chosen_track;
  drs_pkg::tag_t chosen_tag;
  drs_pkg::track_t seek_distance;
  modport source (output valid, output status, output chosen_track, output chosen_tag,
    output seek_distance, input ready);
  modport sink (input valid, input status, input chosen_track, input chosen_tag,
    input seek_distance, output ready);
endinterface
`default_nettype wire

>>> src/disk_request_scheduler.sv
// top level: request tables, selection scan and result register
// An enqueue, a complete, a no-op or a refused issue needs no scan. Its result is presented in the
// cycle after acceptance, and the next item is accepted once that result is taken. An issue
// scans the active table one entry per cycle, up to 32 entries, then registers the result
// in S_OUT and removes the chosen entry in S_SHIFT by shifting the cell row. One item is
// worked on at a time; the result register holds a result until taken and a new item is
// accepted once it is taken. Tie breaking follows the mode: ties to the earliest tag, except
// the reversing pass of LOOK and F-LOOK, which takes the latest tag; equal entries go to the
// oldest. policy_mode values 5 to 7 act as FIFO.
`default_nettype none
module disk_request_scheduler (
  input  wire logic clk,
  input  wire logic rst,
  drs_req_if.sink req,
  drs_rsp_if.source rsp,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  localparam logic [1:0] AddrMode = 2'd0;

  logic [2:0] policy_mode;
  drs_pkg::fsm_t state, state_next;
  drs_pkg::cnt_t act_count, def_count;
  drs_pkg::track_t head_track;
  logic sweep_up, in_service;
  drs_pkg::entry_t act_data [drs_pkg::QueueDepth];
  drs_pkg::entry_t def_data [drs_pkg::QueueDepth];
  drs_pkg::cell_ctl_t act_ctl, def_ctl;

  // scan state
  drs_pkg::cnt_t scan_i;
  logic found_a, found_b;
  drs_pkg::idx_t best_a, best_b;
  drs_pkg::entry_t ent_a, ent_b;
  drs_pkg::track_t dist_a;

  // result register
  logic rsp_valid;
  logic [2:0] r_status;
  drs_pkg::track_t r_track, r_dist;
  drs_pkg::tag_t r_tag;
  drs_pkg::idx_t rm_idx;

  logic op_go;
  assign req.ready = (state == drs_pkg::S_IDLE) && !rsp_valid;
  assign op_go = req.valid && req.ready;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == AddrMode) ? {29'd0, policy_mode} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode <= 3'd0;
    end else if (psel && penable && pwrite && paddr == AddrMode) begin
      policy_mode <= pwdata[2:0];
    end
  end

  logic is_look, is_clook, is_sstf;
  assign is_sstf = policy_mode == drs_pkg::MODE_SSTF;
  assign is_look = policy_mode == drs_pkg::MODE_LOOK || policy_mode == drs_pkg::MODE_FLOOK;
  assign is_clook = policy_mode == drs_pkg::MODE_CLOOK;

  // current scanned entry and its candidacy
  drs_pkg::entry_t cur;
  drs_pkg::track_t cur_dist;
  logic in_region, take_a, take_b;
  assign cur = act_data[scan_i[drs_pkg::IdxBits-1:0]];
  assign cur_dist = (cur.trk > head_track) ? cur.trk - head_track : head_track - cur.trk;

  always_comb begin
    in_region = 1'b1;
    take_a = 1'b0;
    take_b = 1'b0;
    if (is_sstf) begin
      take_a = !found_a || cur_dist < dist_a || (cur_dist == dist_a && cur.tg < ent_a.tg);
    end else if (is_look) begin
      if (sweep_up) begin
        in_region = cur.trk >= head_track;
        take_a = in_region && (!found_a || cur.trk < ent_a.trk ||
                 (cur.trk == ent_a.trk && cur.tg < ent_a.tg));
        take_b = !found_b || cur.trk > ent_b.trk ||
                 (cur.trk == ent_b.trk && cur.tg > ent_b.tg);
      end else begin
        in_region = cur.trk <= head_track;
        take_a = in_region && (!found_a || cur.trk > ent_a.trk ||
                 (cur.trk == ent_a.trk && cur.tg < ent_a.tg));
        take_b = !found_b || cur.trk < ent_b.trk ||
                 (cur.trk == ent_b.trk && cur.tg > ent_b.tg);
      end
    end else if (is_clook) begin
      in_region = cur.trk >= head_track;
      take_a = in_region && (!found_a || cur.trk < ent_a.trk ||
               (cur.trk == ent_a.trk && cur.tg < ent_a.tg));
      take_b = !found_b || cur.trk < ent_b.trk ||
               (cur.trk == ent_b.trk && cur.tg < ent_b.tg);
    end else begin
      take_a = !found_a;
    end
  end

  logic scan_last;
  assign scan_last = (scan_i + drs_pkg::cnt_t'(1)) == act_count;

  // final pick
  drs_pkg::entry_t pick;
  drs_pkg::idx_t pick_idx;
  assign pick = found_a ? ent_a : ent_b;
  assign pick_idx = found_a ? best_a : best_b;

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      drs_pkg::S_IDLE: begin
        if (op_go && req.opcode == drs_pkg::OP_ISSUE && !in_service
            && act_count != '0) begin
          state_next = drs_pkg::S_SCAN;
        end
      end
      drs_pkg::S_SCAN: if (scan_last) state_next = drs_pkg::S_OUT;
      drs_pkg::S_OUT: state_next = drs_pkg::S_SHIFT;
      drs_pkg::S_SHIFT: state_next = drs_pkg::S_IDLE;
      default: state_next = drs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= drs_pkg::S_IDLE;
    else state <= state_next;
  end

  logic enq, to_def, swap;
  assign enq = op_go && req.opcode == drs_pkg::OP_ENQ;
  assign to_def = policy_mode == drs_pkg::MODE_FLOOK && in_service;
  assign swap = op_go && req.opcode == drs_pkg::OP_DONE &&
                policy_mode == drs_pkg::MODE_FLOOK && act_count == '0;

  // cell controls
  always_comb begin
    act_ctl = '0;
    def_ctl = '0;
    act_ctl.push_data = '{trk: req.request_track, tg: req.request_tag};
    def_ctl.push_data = act_ctl.push_data;
    act_ctl.push = enq && !to_def && act_count != drs_pkg::cnt_t'(drs_pkg::QueueDepth);
    def_ctl.push = enq && to_def && def_count != drs_pkg::cnt_t'(drs_pkg::QueueDepth);
    act_ctl.load = swap;
    act_ctl.shift = state == drs_pkg::S_SHIFT;
    act_ctl.remove_idx = rm_idx;
  end

  drs_table u_act (.clk(clk), .ctl(act_ctl), .count(act_count), .load_data(def_data),
    .data(act_data));
  drs_table u_def (.clk(clk), .ctl(def_ctl), .count(def_count), .load_data(def_data),
    .data(def_data));

  // scan registers
  always_ff @(posedge clk) begin
    if (state == drs_pkg::S_IDLE) begin
      scan_i <= '0;
      found_a <= 1'b0;
      found_b <= 1'b0;
    end else if (state == drs_pkg::S_SCAN) begin
      scan_i <= scan_i + drs_pkg::cnt_t'(1);
      if (take_a) begin
        found_a <= 1'b1;
        best_a <= scan_i[drs_pkg::IdxBits-1:0];
        ent_a <= cur;
        dist_a <= cur_dist;
      end
      if (take_b && (is_look || is_clook)) begin
        found_b <= 1'b1;
        best_b <= scan_i[drs_pkg::IdxBits-1:0];
        ent_b <= cur;
      end
    end
  end

  // control state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      act_count <= '0;
      def_count <= '0;
      head_track <= '0;
      sweep_up <= 1'b1;
      in_service <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready) rsp_valid <= 1'b0;
      if (act_ctl.push) act_count <= act_count + drs_pkg::cnt_t'(1);
      if (def_ctl.push) def_count <= def_count + drs_pkg::cnt_t'(1);
      if (op_go) begin
        r_track <= '0;
        r_tag <= '0;
        r_dist <= '0;
        unique case (req.opcode)
          drs_pkg::OP_ENQ: begin
            rsp_valid <= 1'b1;
            r_status <= (act_ctl.push || def_ctl.push) ? drs_pkg::ST_ENQ : drs_pkg::ST_DROP;
          end
          drs_pkg::OP_ISSUE: begin
            if (in_service || act_count == '0) begin
              rsp_valid <= 1'b1;
              r_status <= drs_pkg::ST_NONE;
            end
          end
          drs_pkg::OP_DONE: begin
            rsp_valid <= 1'b1;
            r_status <= drs_pkg::ST_DONE;
            in_service <= 1'b0;
            if (swap) begin
              act_count <= def_count;
              def_count <= '0;
              sweep_up <= 1'b1;
            end
          end
          default: begin
            rsp_valid <= 1'b1;
            r_status <= drs_pkg::ST_NONE;
          end
        endcase
      end
      if (state == drs_pkg::S_OUT) begin
        rsp_valid <= 1'b1;
        r_status <= drs_pkg::ST_ISSUED;
        r_track <= pick.trk;
        r_tag <= pick.tg;
        r_dist <= (pick.trk > head_track) ? pick.trk - head_track : head_track - pick.trk;
        if (pick.trk != head_track) sweep_up <= pick.trk > head_track;
        head_track <= pick.trk;
        rm_idx <= pick_idx;
        in_service <= 1'b1;
      end
      if (state == drs_pkg::S_SHIFT) act_count <= act_count - drs_pkg::cnt_t'(1);
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.status = r_status;
  assign rsp.chosen_track = r_track;
  assign rsp.chosen_tag = r_tag;
  assign rsp.seek_distance = r_dist;

  // no item is taken while an issue is in progress
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != drs_pkg::S_IDLE |-> !req.ready) else $error("accept while busy");
  // a scan always finds some entry
  a_scan_found: assert property (@(posedge clk) disable iff (rst)
    state == drs_pkg::S_OUT |-> (found_a || found_b)) else $error("empty pick");
  // counts never exceed the table depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    act_count <= drs_pkg::cnt_t'(drs_pkg::QueueDepth) &&
    def_count <= drs_pkg::cnt_t'(drs_pkg::QueueDepth)) else $error("count overflow");
endmodule
`default_nettype wire

>>> src/drs_cell.sv
// one table slot: holds an entry and shifts toward the front on removal
`default_nettype none
module drs_cell (
  input  wire logic clk,
  input  wire drs_pkg::cell_ctl_t ctl,
  input  wire drs_pkg::idx_t my_idx,
  input  wire drs_pkg::cnt_t count,
  input  wire drs_pkg::entry_t from_next,
  input  wire drs_pkg::entry_t load_data,
  output drs_pkg::entry_t data
);
  // push writes the slot at count, shift closes the gap, load copies a whole table
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data <= load_data;
    end else if (ctl.push && count == drs_pkg::cnt_t'(my_idx)) begin
      data <= ctl.push_data;
    end else if (ctl.shift && my_idx >= ctl.remove_idx) begin
      data <= from_next;
    end
  end
endmodule
`default_nettype wire

>>> src/drs_table.sv
// row of cells forming one request table
`default_nettype none
module drs_table (
  input  wire logic clk,
  input  wire drs_pkg::cell_ctl_t ctl,
  input  wire drs_pkg::cnt_t count,
  input  wire drs_pkg::entry_t load_data [drs_pkg::QueueDepth],
  output drs_pkg::entry_t data [drs_pkg::QueueDepth]
);
  genvar i;
  generate
    for (i = 0; i < drs_pkg::QueueDepth; i++) begin : g_cell
      drs_pkg::entry_t nxt;
      if (i == drs_pkg::QueueDepth - 1) begin : g_last
        assign nxt = data[i];
      end else begin : g_mid
        assign nxt = data[i+1];
      end
      drs_cell u_cell (
        .clk(clk), .ctl(ctl), .my_idx(drs_pkg::idx_t'(i)), .count(count),
        .from_next(nxt), .load_data(load_data[i]), .data(data[i])
      );
    end
  endgenerate
endmodule
`default_nettype wire
